// File: rtl/ctas_pkg.sv
// ----------------------------------------------------------------------------
// ctas_pkg
// Shared types and constants for the complete tree array store: capacity,
// derived index widths, action codes, result status codes and the
// traversal walker interface.
// ----------------------------------------------------------------------------
package ctas_pkg;

    // Number of node slots in the tree memory.
    localparam int CAPACITY = 64;

    // Node count holds 0..CAPACITY.
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    // Memory address of one node slot.
    localparam int ADR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Child index 2i+2 of the deepest slot needs two bits more than an address.
    localparam int CHILD_W = ADR_W + 2;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int HEIGHT_W = 4;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_SEARCH = 3'd2,
        ACT_LEVEL  = 3'd3,
        ACT_PRE    = 3'd4,
        ACT_IN     = 3'd5,
        ACT_POST   = 3'd6,
        ACT_HEIGHT = 3'd7
    } t_action;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [HEIGHT_W-1:0] HT_EMPTY = -4'sd1;

    typedef enum logic [1:0] {
        WM_PRE  = 2'd0,
        WM_IN   = 2'd1,
        WM_POST = 2'd2
    } t_walk_mode;

    // Per-cycle report of the depth-first walker to the controller.
    typedef struct packed {
        logic             emit;  // a node is visited in output order this cycle
        logic [ADR_W-1:0] addr;  // slot of that node
        logic             done;  // the walk has returned to the root
    } t_walk_out;

endpackage

// File: rtl/ctas_mem.sv
// ----------------------------------------------------------------------------
// ctas_mem
// Node value store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ctas_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ctas_pkg::ADR_W-1:0] i_waddr,
    input  logic [ctas_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [ctas_pkg::ADR_W-1:0] i_raddr,
    output logic [ctas_pkg::DATA_W-1:0] o_rdata
);
    import ctas_pkg::*;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ctas_walk.sv
// ----------------------------------------------------------------------------
// ctas_walk
// Stackless depth-first walker over the implicit tree. It takes one step per
// cycle and visits every node three times: on arrival from the parent, after
// its left subtree and after its right subtree. Moving up uses the parent
// relation (i-1)/2. The walker flags the node that is due in pre, in or post
// order.
// ----------------------------------------------------------------------------
module ctas_walk (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  ctas_pkg::t_walk_mode       i_mode,
    input  logic [ctas_pkg::CNT_W-1:0] i_count,
    output ctas_pkg::t_walk_out        o_walk
);
    import ctas_pkg::*;

    typedef enum logic [3:0] {
        W_IDLE = 4'b0001,
        W_DOWN = 4'b0010,  // just arrived from the parent
        W_UPL  = 4'b0100,  // left subtree finished
        W_UPR  = 4'b1000   // right subtree finished
    } t_wstate;

    t_wstate            r_state, n_state;
    logic [ADR_W-1:0]   r_idx, n_idx;
    t_walk_mode         r_mode, n_mode;

    logic [CHILD_W-1:0] left, right, count_x;

    assign left    = {1'b0, r_idx, 1'b1};
    assign right   = left + CHILD_W'(1);
    assign count_x = CHILD_W'(i_count);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_mode  = r_mode;
        o_walk  = '0;
        o_walk.addr = r_idx;
        unique case (r_state)
            W_IDLE: begin
                if (i_start) begin
                    n_state = W_DOWN;
                    n_idx   = '0;
                    n_mode  = i_mode;
                end
            end
            W_DOWN: begin
                o_walk.emit = (r_mode == WM_PRE);
                if (left < count_x) begin
                    n_idx = left[ADR_W-1:0];
                end else begin
                    n_state = W_UPL;
                end
            end
            W_UPL: begin
                o_walk.emit = (r_mode == WM_IN);
                if (right < count_x) begin
                    n_idx   = right[ADR_W-1:0];
                    n_state = W_DOWN;
                end else begin
                    n_state = W_UPR;
                end
            end
            W_UPR: begin
                o_walk.emit = (r_mode == WM_POST);
                if (r_idx == '0) begin
                    o_walk.done = 1'b1;
                    n_state     = W_IDLE;
                end else begin
                    n_idx   = (r_idx - ADR_W'(1)) >> 1;
                    // An odd slot is a left child, an even one a right child.
                    n_state = r_idx[0] ? W_UPL : W_UPR;
                end
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx  <= n_idx;
        r_mode <= n_mode;
    end

endmodule

// File: rtl/complete_tree_array_store_core.sv
// ----------------------------------------------------------------------------
// complete_tree_array_store_core
// Complete binary tree kept as an implicit array (children of slot i at 2i+1
// and 2i+2) with a node count. Supports append, delete-last, search, level,
// pre, in and post order traversal, and height.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// command   in         start & !busy          i_action, i_value
// result    out        o_valid, no backpress  o_status, o_found, o_item,
//                                             o_height, o_last
//
// Insert, delete and height take one transaction and show their result in
// the cycle right after the accepting edge, with busy low again at once.
// Search and level order read one slot per cycle from the node memory.
// Pre, in and post order are paced by the walker, which visits every node
// three times (arrival, after the left subtree, after the right subtree).
// Reset (synchronous, active low) empties the tree; memory contents are kept
// but are never read before being written again.
// Results cannot be stalled: each one is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module complete_tree_array_store_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [2:0]                           i_action,
    input  logic signed [ctas_pkg::DATA_W-1:0]   i_value,
    output logic                                 o_valid,
    output logic [ctas_pkg::STATUS_W-1:0]        o_status,
    output logic                                 o_found,
    output logic signed [ctas_pkg::DATA_W-1:0]   o_item,
    output logic signed [ctas_pkg::HEIGHT_W-1:0] o_height,
    output logic                                 o_last
);
    import ctas_pkg::*;

    // Controller states. SCAN walks slots in index order (search and level
    // order), WALK follows the depth-first walker.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WALK = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Tree size and scan position; the scan counter also numbers emitted
    // nodes during a depth-first walk so that the final one is marked.
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_scan, n_scan;
    logic [DATA_W-1:0] r_value, n_value;
    logic              r_hit, n_hit;
    logic              r_srch, n_srch;

    // Read tag: travels beside the memory read so that the returning data
    // knows what it is for.
    logic r_tag_v, n_tag_v;
    logic r_tag_last, n_tag_last;

    // Output register.
    logic                       r_out_v, n_out_v;
    logic [STATUS_W-1:0]        r_status, n_status;
    logic                       r_found, n_found;
    logic signed [DATA_W-1:0]   r_item, n_item;
    logic signed [HEIGHT_W-1:0] r_height, n_height;
    logic                       r_last, n_last;

    // Memory port signals.
    logic              wr_en, rd_en;
    logic [ADR_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_q;

    // Walker interface.
    logic       walk_start;
    t_walk_mode walk_mode;
    t_walk_out  walk;

    logic                       accept;
    logic                       is_empty;
    logic                       scan_last;
    logic                       hit_now;
    logic signed [HEIGHT_W-1:0] tree_height;
    t_action                    action;

    assign action    = t_action'(i_action);
    assign accept    = start && !busy;
    assign is_empty  = (r_count == '0);
    assign scan_last = (r_scan == r_count - CNT_W'(1));
    assign hit_now   = r_hit || (rd_q == r_value);

    // The controller takes a new command only in IDLE with no read in flight.
    assign busy = (r_state != S_IDLE) || r_tag_v;

    // Height is the position of the leading one of the node count.
    always_comb begin
        tree_height = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (r_count[b]) begin
                tree_height = HEIGHT_W'(b);
            end
        end
    end

    always_comb begin
        case (action)
            ACT_PRE: walk_mode = WM_PRE;
            ACT_IN:  walk_mode = WM_IN;
            default: walk_mode = WM_POST;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_scan     = r_scan;
        n_value    = r_value;
        n_hit      = r_hit;
        n_srch     = r_srch;
        n_tag_v    = 1'b0;
        n_tag_last = 1'b0;
        n_out_v    = 1'b0;
        n_status   = ST_OK;
        n_found    = 1'b0;
        n_item     = '0;
        n_height   = '0;
        n_last     = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_scan[ADR_W-1:0];
        walk_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // Single-result commands finish here; every empty-tree
                    // case is also answered at once.
                    n_out_v = 1'b1;
                    n_last  = 1'b1;
                    unique case (action) inside
                        ACT_INSERT: begin
                            if (r_count < CNT_W'(CAPACITY)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        ACT_DELETE: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        ACT_SEARCH, ACT_LEVEL: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_out_v = 1'b0;
                                n_last  = 1'b0;
                                n_state = S_SCAN;
                                n_scan  = '0;
                                n_value = i_value;
                                n_hit   = 1'b0;
                                n_srch  = (action == ACT_SEARCH);
                            end
                        end
                        ACT_PRE, ACT_IN, ACT_POST: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_out_v    = 1'b0;
                                n_last     = 1'b0;
                                n_state    = S_WALK;
                                n_scan     = '0;
                                n_srch     = 1'b0;
                                walk_start = 1'b1;
                            end
                        end
                        ACT_HEIGHT: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                                n_height = HT_EMPTY;
                            end else begin
                                n_height = tree_height;
                            end
                        end
                        default: begin
                            n_out_v = 1'b0;
                            n_last  = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                rd_en      = 1'b1;
                n_tag_v    = 1'b1;
                n_tag_last = scan_last;
                n_scan     = r_scan + CNT_W'(1);
                if (scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                rd_addr = walk.addr;
                if (walk.emit) begin
                    rd_en      = 1'b1;
                    n_tag_v    = 1'b1;
                    n_tag_last = scan_last;
                    n_scan     = r_scan + CNT_W'(1);
                end
                if (walk.done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Returning read data. No command is accepted while a read is in
        // flight, so this never meets a single-result command above.
        if (r_tag_v) begin
            if (r_srch) begin
                if (r_tag_last) begin
                    n_out_v = 1'b1;
                    n_last  = 1'b1;
                    n_found = hit_now;
                    n_hit   = 1'b0;
                end else begin
                    n_hit = hit_now;
                end
            end else begin
                n_out_v = 1'b1;
                n_item  = $signed(rd_q);
                n_last  = r_tag_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_tag_v <= 1'b0;
            r_out_v <= 1'b0;
            r_hit   <= 1'b0;
            r_srch  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_tag_v <= n_tag_v;
            r_out_v <= n_out_v;
            r_hit   <= n_hit;
            r_srch  <= n_srch;
        end
        r_scan     <= n_scan;
        r_value    <= n_value;
        r_tag_last <= n_tag_last;
        r_status   <= n_status;
        r_found    <= n_found;
        r_item     <= n_item;
        r_height   <= n_height;
        r_last     <= n_last;
    end

    ctas_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[ADR_W-1:0]),
        .i_wdata (i_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_q)
    );

    ctas_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (walk_start),
        .i_mode  (walk_mode),
        .i_count (r_count),
        .o_walk  (walk)
    );

    assign o_valid  = r_out_v;
    assign o_status = r_status;
    assign o_found  = r_found;
    assign o_item   = r_item;
    assign o_height = r_height;
    assign o_last   = r_last;

endmodule

// File: bench/ctas_tb_pkg.sv
// ----------------------------------------------------------------------------
// ctas_tb_pkg
// Shadow copy of the complete tree array store for the testbench. It keeps
// its own node slots and node count, works out the results that every
// accepted command must produce, and compares the block's results against
// them in order.
// ----------------------------------------------------------------------------
package ctas_tb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import ctas_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [DATA_W-1:0]   item;
        logic [HEIGHT_W-1:0] height;
        logic                last;
    } t_tree_result;

    class t_tree_shadow;
        logic [DATA_W-1:0] slots [CAPACITY];
        int unsigned       node_count;
        t_tree_result      awaited_q [$];
        int unsigned       errors;

        function new();
            node_count = 0;
            errors     = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function void post(logic [STATUS_W-1:0] status, logic found,
                           logic [DATA_W-1:0] item, logic [HEIGHT_W-1:0] height);
            t_tree_result r;
            r.status = status;
            r.found  = found;
            r.item   = item;
            r.height = height;
            r.last   = 1'b0;
            awaited_q.push_back(r);
        endfunction

        // Depth-first walk over the implicit tree; the order decides where
        // a node is emitted relative to its two subtrees.
        function void walk(int unsigned idx, t_action order);
            if (idx >= node_count) return;
            if (order == ACT_PRE) post(ST_OK, 1'b0, slots[idx], '0);
            walk(2 * idx + 1, order);
            if (order == ACT_IN) post(ST_OK, 1'b0, slots[idx], '0);
            walk(2 * idx + 2, order);
            if (order == ACT_POST) post(ST_OK, 1'b0, slots[idx], '0);
        endfunction

        // Called once per accepted command transaction.
        function void apply_command(t_action act, logic [DATA_W-1:0] value);
            logic        hit;
            int unsigned h;
            case (act)
                ACT_INSERT: begin
                    if (node_count < CAPACITY) begin
                        slots[node_count] = value;
                        node_count++;
                        post(ST_OK, 1'b0, '0, '0);
                    end else begin
                        post(ST_FULL, 1'b0, '0, '0);
                    end
                end
                ACT_DELETE: begin
                    if (node_count == 0) begin
                        post(ST_EMPTY, 1'b0, '0, '0);
                    end else begin
                        node_count--;
                        post(ST_OK, 1'b0, '0, '0);
                    end
                end
                ACT_SEARCH: begin
                    if (node_count == 0) begin
                        post(ST_EMPTY, 1'b0, '0, '0);
                    end else begin
                        hit = 1'b0;
                        for (int i = 0; i < node_count; i++)
                            if (slots[i] == value) hit = 1'b1;
                        post(ST_OK, hit, '0, '0);
                    end
                end
                ACT_LEVEL, ACT_PRE, ACT_IN, ACT_POST: begin
                    if (node_count == 0) begin
                        post(ST_EMPTY, 1'b0, '0, '0);
                    end else if (act == ACT_LEVEL) begin
                        for (int i = 0; i < node_count; i++)
                            post(ST_OK, 1'b0, slots[i], '0);
                    end else begin
                        walk(0, act);
                    end
                end
                default: begin
                    if (node_count == 0) begin
                        post(ST_EMPTY, 1'b0, '0, HT_EMPTY);
                    end else begin
                        h = 0;
                        while ((node_count >> (h + 1)) != 0) h++;
                        post(ST_OK, 1'b0, '0, HEIGHT_W'(h));
                    end
                end
            endcase
            awaited_q[awaited_q.size() - 1].last = 1'b1;
        endfunction

        function void check_field(string name, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // Called once per result strobe.
        function void compare_result(logic [STATUS_W-1:0] status, logic found,
                                     logic [DATA_W-1:0] item,
                                     logic [HEIGHT_W-1:0] height, logic last);
            t_tree_result want;
            if (awaited_q.size() == 0) begin
                $display("%0t ns: result with none expected, status %h item %h",
                         $time, status, item);
                errors++;
                return;
            end
            want = awaited_q.pop_front();
            check_field("status", DATA_W'(want.status), DATA_W'(status));
            check_field("found",  DATA_W'(want.found),  DATA_W'(found));
            check_field("item",   want.item,            item);
            check_field("height", DATA_W'(want.height), DATA_W'(height));
            check_field("last",   DATA_W'(want.last),   DATA_W'(last));
        endfunction

        // A stored value, so that searches can hit; any value on an empty tree.
        function logic [DATA_W-1:0] pick_stored();
            if (node_count == 0) return $urandom();
            return slots[$urandom_range(0, node_count - 1)];
        endfunction

        function void close_out();
            if (awaited_q.size() != 0) begin
                $display("%0t ns: %0d expected results never arrived",
                         $time, awaited_q.size());
                errors += awaited_q.size();
            end
        endfunction
    endclass

endpackage

// File: bench/complete_tree_array_store_core_tb.sv
// ----------------------------------------------------------------------------
// complete_tree_array_store_core_tb
// Self-checking bench for the complete tree array store. A directed opening
// covers the empty tree, extreme values, every traversal order, search hits
// and misses and height; then random command streams grow the tree to full
// and shrink it back to empty. Every result is checked against a shadow copy
// of the tree kept in the bench.
// ----------------------------------------------------------------------------
module complete_tree_array_store_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ctas_pkg::*;
    import ctas_tb_pkg::*;

    localparam int RANDOM_COMMANDS = 360;
    // Enough to drain whatever is still in flight, a post-order walk of a full
    // tree included.
    localparam int DRAIN_LIMIT   = 8 * CAPACITY + 64;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [2:0]                   i_action;
    logic signed [DATA_W-1:0]     i_value;
    logic                         o_valid;
    logic [STATUS_W-1:0]          o_status;
    logic                         o_found;
    logic signed [DATA_W-1:0]     o_item;
    logic signed [HEIGHT_W-1:0]   o_height;
    logic                         o_last;

    t_tree_shadow shadow = new();

    // Sender pacing: commands go out in bursts, with idle gaps in between.
    int unsigned burst_left = 0;

    complete_tree_array_store_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_action (i_action),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_found  (o_found),
        .o_item   (o_item),
        .o_height (o_height),
        .o_last   (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Monitor. All inputs change by nonblocking assignment at the rising
    // edge, so at the edge both start/busy and the result strobe still hold
    // the values of the cycle that is ending. Results are checked before a
    // new command is noted; a command never produces a result at the edge
    // that accepts it, so the order only matters for readability.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                shadow.compare_result(o_status, o_found, o_item, o_height, o_last);
            if (start && !busy)
                shadow.apply_command(t_action'(i_action), i_value);
        end
    end

    // Value mix: the extremes, a narrow band of small numbers so duplicates
    // are common, values already in the tree, and full random words.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return DATA_W'($urandom_range(0, 7));
            4, 5:    return shadow.pick_stored();
            default: return $urandom();
        endcase
    endfunction

    // After each accepted transaction, either keep start high for the next
    // command in the burst or drop it for a random gap. Now and then a
    // long burst runs without any gap at all.
    task automatic pace();
        int unsigned gap;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Present one command and hold it until the block takes it. Called at
    // a rising edge; returns at the edge that accepts the transaction, or after the idle gap that follows it.
    task automatic send_command(t_action act, logic [DATA_W-1:0] value);
        start    <= 1'b1;
        i_action <= act;
        i_value  <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pace();
    endtask

    initial begin
        t_action     act;
        int unsigned roll;
        int unsigned fill;
        int unsigned waited;
        bit          growing;

        // Every input is known from time zero, with reset held low at the start.
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_action = ACT_INSERT;
        i_value  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Everything on an empty tree must report empty, height -1 included.
        send_command(ACT_DELETE, $urandom());
        send_command(ACT_SEARCH, 32'h0000_0000);
        send_command(ACT_LEVEL,  $urandom());
        send_command(ACT_PRE,    $urandom());
        send_command(ACT_IN,     $urandom());
        send_command(ACT_POST,   $urandom());
        send_command(ACT_HEIGHT, $urandom());

        // Six nodes with extreme and alternating bit patterns give a tree
        // where the four orders all differ.
        send_command(ACT_INSERT, 32'h8000_0000);
        send_command(ACT_INSERT, 32'h7FFF_FFFF);
        send_command(ACT_INSERT, 32'h0000_0000);
        send_command(ACT_INSERT, 32'hFFFF_FFFF);
        send_command(ACT_INSERT, 32'h5555_5555);
        send_command(ACT_INSERT, 32'hAAAA_AAAA);
        send_command(ACT_HEIGHT, $urandom());
        send_command(ACT_LEVEL,  $urandom());
        send_command(ACT_PRE,    $urandom());
        send_command(ACT_IN,     $urandom());
        send_command(ACT_POST,   $urandom());

        // One search that hits and one that misses.
        send_command(ACT_SEARCH, 32'h7FFF_FFFF);
        send_command(ACT_SEARCH, 32'h1234_5678);

        // Delete-last shrinks the tree; a deleted value must no longer match.
        send_command(ACT_DELETE, $urandom());
        send_command(ACT_SEARCH, 32'hAAAA_AAAA);
        send_command(ACT_HEIGHT, $urandom());

        // Random part. The stream alternates between a growing phase, mostly
        // inserts, and a shrinking phase, mostly deletes, so the tree passes
        // through every size, sits full for a while (inserts get dropped) and
        // then empty for a while. Searches, traversals and height are mixed
        // in throughout.
        fill    = 5;
        growing = 1'b1;
        for (int n = 0; n < RANDOM_COMMANDS; n++) begin
            if (growing && fill == CAPACITY && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            if (!growing && fill == 0 && $urandom_range(0, 2) == 0)
                growing = 1'b1;

            roll = $urandom_range(0, 99);
            if (roll < 55)
                act = growing ? ACT_INSERT : ACT_DELETE;
            else if (roll < 60)
                act = growing ? ACT_DELETE : ACT_INSERT;
            else if (roll < 70)
                act = ACT_SEARCH;
            else if (roll < 90)
                act = t_action'(3'($urandom_range(ACT_LEVEL, ACT_POST)));
            else
                act = ACT_HEIGHT;

            if (act == ACT_INSERT && fill < CAPACITY)
                fill++;
            else if (act == ACT_DELETE && fill > 0)
                fill--;

            if (act == ACT_INSERT || act == ACT_SEARCH)
                send_command(act, pick_value());
            else
                send_command(act, $urandom());
        end
        start <= 1'b0;

        // Let the monitor note the last command, wait for every expected
        // result, then watch a while longer for anything extra.
        @(posedge i_clk);
        waited = 0;
        while (shadow.awaited_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        shadow.close_out();

        if (shadow.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog. The slowest legal run is a few hundred commands, each a full
    // post-order walk plus the longest gap; the limit allows several times that.
    initial begin
        #5ms;
        $display("%0t ns: run timed out", $time);
        $display("TEST FAILED");
        $finish;
    end

endmodule
